// File: src/ptc_pkg.sv
// Shared types, token class codes and byte constants for the PDF token classifier.
package ptc_pkg;

    localparam int MAX_TOKEN_LENGTH_DEFAULT = 4095;
    localparam int HEAD_DEPTH               = 8;
    localparam int FIFO_DEPTH               = 4;
    localparam int LEN_OUT_W                = 12;
    localparam int VALUE_W                  = 31;

    localparam logic [3:0] CLASS_ENDL       = 4'd0;
    localparam logic [3:0] CLASS_INT        = 4'd1;
    localparam logic [3:0] CLASS_NAME       = 4'd2;
    localparam logic [3:0] CLASS_VERSION    = 4'd3;
    localparam logic [3:0] CLASS_CHAR       = 4'd4;
    localparam logic [3:0] CLASS_XREF       = 4'd5;
    localparam logic [3:0] CLASS_TRAILER    = 4'd6;
    localparam logic [3:0] CLASS_OBJ        = 4'd7;
    localparam logic [3:0] CLASS_DICT_END   = 4'd8;
    localparam logic [3:0] CLASS_DICT_BEGIN = 4'd9;
    localparam logic [3:0] CLASS_STRING     = 4'd10;
    localparam logic [3:0] CLASS_INT_OVF    = 4'd11;

    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [3:0]           token_class;
        logic [VALUE_W-1:0]   int_value;
        logic [3:0]           version_minor;
        logic [LEN_OUT_W-1:0] token_length;
        logic                 last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic is_digit(input logic [7:0] b);
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

endpackage

// File: src/ptc_lexer.sv
// Request register, token state and single-pass token classification.
module ptc_lexer #(
    parameter int MAX_TOKEN_LENGTH = ptc_pkg::MAX_TOKEN_LENGTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          cmd,
    input  logic [7:0]    data_byte,
    input  logic          space_ok,
    output ptc_pkg::push_t push
);
    import ptc_pkg::*;

    localparam int LEN_W = $clog2(MAX_TOKEN_LENGTH + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LENGTH);

    logic                 req_valid_reg;
    logic                 cmd_reg;
    logic [7:0]           byte_reg;

    logic                 in_token_reg,   in_token_next;
    logic                 all_digits_reg, all_digits_next;
    logic [LEN_W-1:0]     length_reg,     length_next;
    logic [VALUE_W-1:0]   acc_reg,        acc_next;
    logic                 ovf_reg,        ovf_next;
    logic [7:0]           head_reg [HEAD_DEPTH];

    logic                 proc;
    logic                 is_nl;
    logic                 is_ws;
    logic                 is_data;
    logic [VALUE_W+3:0]   prod;
    logic [16:0]          len_ext;
    logic                 ver_ok;
    result_t              tok;
    result_t              endl;

    assign proc     = req_valid_reg && space_ok;
    assign in_ready = !req_valid_reg || space_ok;

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            req_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg  <= cmd;
            byte_reg <= data_byte;
        end
    end

    assign is_nl   = (cmd_reg == CMD_DATA) && (byte_reg == CH_LF);
    assign is_ws   = (byte_reg == CH_TAB) || (byte_reg == CH_LF) || (byte_reg == CH_VT) ||
                     (byte_reg == CH_FF) || (byte_reg == CH_CR) || (byte_reg == CH_SPACE);
    assign is_data = (cmd_reg == CMD_DATA) && !is_ws;

    // acc * 10 + digit
    assign prod = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                + (VALUE_W+4)'(byte_reg - CH_ZERO);

    assign len_ext = 17'(length_reg);
    assign ver_ok  = (length_reg >= LEN_W'(6)) && (head_reg[0] == "%") &&
                     (head_reg[1] == "P") && (head_reg[2] == "D") && (head_reg[3] == "F") &&
                     (head_reg[4] == "-") && is_digit(head_reg[5]);

    // classification of the pending token
    always_comb
    begin
        tok = '0;
        tok.token_length = (len_ext > 17'd4095) ? 12'hFFF : len_ext[LEN_OUT_W-1:0];
        if (all_digits_reg)
        begin
            if (ovf_reg)
            begin
                tok.token_class = CLASS_INT_OVF;
            end
            else
            begin
                tok.token_class = CLASS_INT;
                tok.int_value   = acc_reg;
            end
        end
        else if (head_reg[0] == CH_SLASH)
        begin
            tok.token_class = CLASS_NAME;
        end
        else if (ver_ok)
        begin
            tok.token_class = CLASS_VERSION;
            tok.int_value   = VALUE_W'(head_reg[5] - CH_ZERO);
            if ((length_reg >= LEN_W'(8)) && (head_reg[6] == CH_DOT) && is_digit(head_reg[7]))
            begin
                tok.version_minor = 4'(head_reg[7] - CH_ZERO);
            end
        end
        else if (length_reg == LEN_W'(1))
        begin
            tok.token_class = CLASS_CHAR;
        end
        else if ((length_reg == LEN_W'(4)) && (head_reg[0] == "x") && (head_reg[1] == "r") &&
                 (head_reg[2] == "e") && (head_reg[3] == "f"))
        begin
            tok.token_class = CLASS_XREF;
        end
        else if ((length_reg == LEN_W'(7)) && (head_reg[0] == "t") && (head_reg[1] == "r") &&
                 (head_reg[2] == "a") && (head_reg[3] == "i") && (head_reg[4] == "l") &&
                 (head_reg[5] == "e") && (head_reg[6] == "r"))
        begin
            tok.token_class = CLASS_TRAILER;
        end
        else if ((length_reg == LEN_W'(3)) && (head_reg[0] == "o") && (head_reg[1] == "b") &&
                 (head_reg[2] == "j"))
        begin
            tok.token_class = CLASS_OBJ;
        end
        else if ((length_reg == LEN_W'(2)) && (head_reg[0] == ">") && (head_reg[1] == ">"))
        begin
            tok.token_class = CLASS_DICT_END;
        end
        else if ((length_reg == LEN_W'(2)) && (head_reg[0] == "<") && (head_reg[1] == "<"))
        begin
            tok.token_class = CLASS_DICT_BEGIN;
        end
        else
        begin
            tok.token_class = CLASS_STRING;
        end
    end

    // results and next token state
    always_comb
    begin
        endl             = '0;
        endl.token_class = CLASS_ENDL;

        push            = '0;
        in_token_next   = in_token_reg;
        all_digits_next = all_digits_reg;
        length_next     = length_reg;
        acc_next        = acc_reg;
        ovf_next        = ovf_reg;

        if (proc)
        begin
            if (is_data)
            begin
                in_token_next = 1'b1;
                if (length_reg < LEN_MAX)
                begin
                    length_next = length_reg + LEN_W'(1);
                end
                if (!is_digit(byte_reg))
                begin
                    all_digits_next = 1'b0;
                end
                else if (all_digits_reg && !ovf_reg)
                begin
                    if (prod[VALUE_W+3:VALUE_W] != 4'd0)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = prod[VALUE_W-1:0];
                    end
                end
            end
            else
            begin
                in_token_next   = 1'b0;
                all_digits_next = 1'b1;
                length_next     = '0;
                acc_next        = '0;
                ovf_next        = 1'b0;
                if (is_nl)
                begin
                    push.count              = in_token_reg ? 2'd2 : 2'd1;
                    push.first              = endl;
                    push.first.last_of_run  = !in_token_reg;
                    push.second             = tok;
                    push.second.last_of_run = 1'b1;
                end
                else if (in_token_reg)
                begin
                    push.count             = 2'd1;
                    push.first             = tok;
                    push.first.last_of_run = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_token_reg   <= 1'b0;
            all_digits_reg <= 1'b1;
            length_reg     <= '0;
            acc_reg        <= '0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            in_token_reg   <= in_token_next;
            all_digits_reg <= all_digits_next;
            length_reg     <= length_next;
            acc_reg        <= acc_next;
            ovf_reg        <= ovf_next;
        end
    end

    // first bytes of the token
    always_ff @(posedge clk)
    begin
        if (proc && is_data && (length_reg < LEN_W'(HEAD_DEPTH)))
        begin
            head_reg[length_reg[2:0]] <= byte_reg;
        end
    end

endmodule

// File: src/ptc_out_fifo.sv
// Result queue taking up to two results per cycle and issuing one per cycle while out_ready is high.
module ptc_out_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  ptc_pkg::push_t   push,
    output logic             space_ok,
    output logic             out_valid,
    input  logic             out_ready,
    output ptc_pkg::result_t head
);
    import ptc_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    result_t          mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign space_ok  = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= push.second;
        end
    end

endmodule

// File: src/pdf_token_classifier.sv
// PDF token classifier: top level joining the lexer and the result queue.
// An accepted request is held in the lexer's request register, and its results in the result queue.
// Throughput: one request per cycle while each gives at most one result and out_ready stays
// high; results leave at one per cycle then, so a newline ending a token costs one extra output slot.
// The lexer processes a request only while the four-entry result queue has at least two free entries.
// Reset clears the token state and empties the queue; the head-byte store is not cleared.
module pdf_token_classifier #(
    parameter int MAX_TOKEN_LENGTH = ptc_pkg::MAX_TOKEN_LENGTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  token_class,
    output logic [30:0] int_value,
    output logic [3:0]  version_minor,
    output logic [11:0] token_length,
    output logic        last_of_run
);
    import ptc_pkg::*;

    push_t   push;
    logic    space_ok;
    result_t head;

    ptc_lexer #(
        .MAX_TOKEN_LENGTH(MAX_TOKEN_LENGTH)
    ) u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .data_byte (data_byte),
        .space_ok  (space_ok),
        .push      (push)
    );

    ptc_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign token_class   = head.token_class;
    assign int_value     = head.int_value;
    assign version_minor = head.version_minor;
    assign token_length  = head.token_length;
    assign last_of_run   = head.last_of_run;

endmodule

// File: dv/tb.sv
// Self-checking testbench for the PDF token classifier: random byte streams, predicted tokens.
`timescale 1ns / 1ps

module tb;
    import ptc_pkg::*;

    localparam int          LIMIT_CYCLES = 400000;
    localparam int          RAND_REQS    = 1650;
    localparam int          LONG_LEN     = 300;
    localparam int unsigned MAX_LEN      = MAX_TOKEN_LENGTH_DEFAULT;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } lex_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        cmd = CMD_DATA;
    logic [7:0]  data_byte = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  token_class;
    logic [30:0] int_value;
    logic [3:0]  version_minor;
    logic [11:0] token_length;
    logic        last_of_run;

    lex_req_t    req_q[$];
    result_t     token_q[$];
    logic        req_taken = 1'b0;
    int          n_taken = 0;
    int          errors = 0;
    int          cycle_cnt = 0;

    // lexer state of the predictor
    logic        tok_open;
    logic        tok_digits;
    logic        tok_ovf;
    int unsigned tok_len;
    longint unsigned tok_value;
    logic [7:0]  tok_head [HEAD_DEPTH];

    pdf_token_classifier u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .token_class   (token_class),
        .int_value     (int_value),
        .version_minor (version_minor),
        .token_length  (token_length),
        .last_of_run   (last_of_run)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic is_space(input logic [7:0] b);
        return b == CH_TAB || b == CH_LF || b == CH_VT || b == CH_FF || b == CH_CR ||
               b == CH_SPACE;
    endfunction

    function automatic logic is_dec(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic head_matches(input string s, input logic exact);
        if (exact ? (tok_len != s.len()) : (tok_len < s.len()))
            return 1'b0;
        for (int i = 0; i < s.len(); i++)
            if (tok_head[i] != s[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic result_t classify_token();
        result_t r;
        r = '0;
        r.token_class = CLASS_STRING;
        if (tok_digits)
        begin
            if (tok_ovf)
                r.token_class = CLASS_INT_OVF;
            else
            begin
                r.token_class = CLASS_INT;
                r.int_value   = tok_value[30:0];
            end
        end
        else if (tok_head[0] == CH_SLASH)
            r.token_class = CLASS_NAME;
        else if (head_matches("%PDF-", 1'b0) && tok_len >= 6 && is_dec(tok_head[5]))
        begin
            r.token_class = CLASS_VERSION;
            r.int_value   = 31'(tok_head[5] - 8'h30);
            if (tok_len >= 8 && tok_head[6] == CH_DOT && is_dec(tok_head[7]))
                r.version_minor = 4'(tok_head[7] - 8'h30);
        end
        else if (tok_len == 1)
            r.token_class = CLASS_CHAR;
        else if (head_matches("xref", 1'b1))
            r.token_class = CLASS_XREF;
        else if (head_matches("trailer", 1'b1))
            r.token_class = CLASS_TRAILER;
        else if (head_matches("obj", 1'b1))
            r.token_class = CLASS_OBJ;
        else if (head_matches(">>", 1'b1))
            r.token_class = CLASS_DICT_END;
        else if (head_matches("<<", 1'b1))
            r.token_class = CLASS_DICT_BEGIN;
        r.token_length = (tok_len > 4095) ? 12'd4095 : 12'(tok_len);
        return r;
    endfunction

    function automatic void clear_token();
        tok_open   = 1'b0;
        tok_digits = 1'b1;
        tok_ovf    = 1'b0;
        tok_len    = 0;
        tok_value  = 0;
    endfunction

    // works out the results of one accepted request and queues them
    function automatic void lex_request(input lex_req_t q);
        result_t outs [2];
        int n;
        longint unsigned v;
        n = 0;
        if (q.cmd == CMD_FLUSH || is_space(q.data_byte))
        begin
            if (q.cmd == CMD_DATA && q.data_byte == CH_LF)
            begin
                outs[n] = '0;
                outs[n].token_class = CLASS_ENDL;
                n++;
            end
            if (tok_open)
            begin
                outs[n] = classify_token();
                n++;
            end
            clear_token();
        end
        else
        begin
            if (tok_len < HEAD_DEPTH)
                tok_head[tok_len] = q.data_byte;
            if (tok_len < MAX_LEN)
                tok_len++;
            tok_open = 1'b1;
            if (!is_dec(q.data_byte))
                tok_digits = 1'b0;
            else if (tok_digits && !tok_ovf)
            begin
                v = tok_value * 10 + (q.data_byte - 8'h30);
                if (v > 64'd2147483647)
                    tok_ovf = 1'b1;
                else
                    tok_value = v;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            outs[i].last_of_run = (i == n - 1);
            token_q.insert(token_q.size(), outs[i]);
        end
    endfunction

    function automatic logic calm();
        return n_taken >= 300 && n_taken < 800;
    endfunction

    function automatic logic [7:0] any_tok_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (is_space(b))
            b = 8'($urandom_range(255));
        return b;
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        lex_req_t q;
        q.cmd       = CMD_DATA;
        q.data_byte = b;
        req_q.insert(req_q.size(), q);
    endfunction

    function automatic void add_flush();
        lex_req_t q;
        q.cmd       = CMD_FLUSH;
        q.data_byte = 8'($urandom_range(255));
        req_q.insert(req_q.size(), q);
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    function automatic void add_rand_bytes(input int n);
        for (int i = 0; i < n; i++)
            add_byte(any_tok_byte());
    endfunction

    function automatic void add_digits(input int n);
        for (int i = 0; i < n; i++)
            add_byte(8'h30 + 8'($urandom_range(9)));
    endfunction

    function automatic void add_separator();
        logic [7:0] spaces [6];
        int k;
        spaces = '{CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_SPACE};
        k = $urandom_range(9);
        if (k == 0)
            add_flush();
        else
            add_byte(spaces[$urandom_range(5)]);
    endfunction

    function automatic void add_token();
        string words [13];
        int k;
        words = '{"xref", "trailer", "obj", ">>", "<<", "xre", "xrefs", "trailers",
                  "ob", "objx", ">>>", "<", "trai"};
        k = $urandom_range(99);
        if (k < 15)
            add_digits($urandom_range(1, 10));
        else if (k < 18)
            add_text($urandom_range(1) ? "2147483647" : "2147483648");
        else if (k < 22)
            add_digits($urandom_range(11, 24));
        else if (k < 32)
        begin
            add_byte(CH_SLASH);
            add_rand_bytes($urandom_range(0, 6));
        end
        else if (k < 44)
        begin
            add_text("%PDF-");
            add_byte(8'h30 + 8'($urandom_range(9)));
            case ($urandom_range(3))
                0: ;
                1:
                begin
                    add_byte(CH_DOT);
                    add_byte(8'h30 + 8'($urandom_range(9)));
                end
                2:
                begin
                    add_byte(CH_DOT);
                    add_rand_bytes(1);
                end
                default: add_rand_bytes($urandom_range(1, 4));
            endcase
        end
        else if (k < 48)
        begin
            add_text($urandom_range(1) ? "%PDF-" : "%PDF");
            add_rand_bytes($urandom_range(0, 2));
        end
        else if (k < 58)
            add_rand_bytes(1);
        else if (k < 78)
            add_text(words[$urandom_range(12)]);
        else if (k < 92)
            add_rand_bytes($urandom_range(2, 12));
        else
        begin
            // noise: any byte or a bare flush
            for (int i = $urandom_range(1, 4); i > 0; i--)
                if ($urandom_range(4) == 0)
                    add_flush();
                else
                    add_byte(8'($urandom_range(255)));
        end
    endfunction

    // driver: new request at the falling edge once the current one is taken
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || req_taken))
        begin
            if (req_q.size() != 0 && (calm() || $urandom_range(99) >= 30))
            begin
                cmd       <= req_q[0].cmd;
                data_byte <= req_q[0].data_byte;
                in_valid  <= 1'b1;
                void'(req_q.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
        out_ready <= rst_n && (calm() || $urandom_range(99) >= 30);
    end

    // request side: prediction at acceptance
    always @(posedge clk)
    begin
        lex_req_t q;
        cycle_cnt <= cycle_cnt + 1;
        req_taken <= in_valid && in_ready;
        if (in_valid && in_ready)
        begin
            q.cmd       = cmd;
            q.data_byte = data_byte;
            lex_request(q);
            n_taken <= n_taken + 1;
        end
        if (cycle_cnt == LIMIT_CYCLES)
        begin
            $display("%0t: timeout, %0d requests and %0d results outstanding",
                     $realtime, req_q.size(), token_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side
    always @(posedge clk)
    begin
        result_t got;
        result_t exp_r;
        if (out_valid && out_ready)
        begin
            got.token_class   = token_class;
            got.int_value     = int_value;
            got.version_minor = version_minor;
            got.token_length  = token_length;
            got.last_of_run   = last_of_run;
            if (token_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result class=%0d val=%0d minor=%0d len=%0d last=%0d",
                         $realtime, got.token_class, got.int_value, got.version_minor,
                         got.token_length, got.last_of_run);
            end
            else
            begin
                exp_r = token_q.pop_front();
                if (got.token_class != exp_r.token_class || got.int_value != exp_r.int_value ||
                    got.version_minor != exp_r.version_minor ||
                    got.token_length != exp_r.token_length ||
                    got.last_of_run != exp_r.last_of_run)
                begin
                    errors++;
                    $display("%0t: mismatch exp class=%0d val=%0d minor=%0d len=%0d last=%0d",
                             $realtime, exp_r.token_class, exp_r.int_value,
                             exp_r.version_minor, exp_r.token_length, exp_r.last_of_run);
                    $display("%0t:          got class=%0d val=%0d minor=%0d len=%0d last=%0d",
                             $realtime, got.token_class, got.int_value, got.version_minor,
                             got.token_length, got.last_of_run);
                end
            end
        end
    end

    initial
    begin
        int n_direct;
        logic long_done;
        clear_token();
        for (int i = 0; i < HEAD_DEPTH; i++)
            tok_head[i] = 8'd0;

        // directed: xref keyword, dict marks, name with top byte, version, empty flush, zero byte
        add_text("xref");
        add_byte(CH_LF);
        add_text("<<");
        add_byte(CH_TAB);
        add_text(">>");
        add_byte(CH_CR);
        add_byte(CH_SLASH);
        add_byte(8'hFF);
        add_byte(CH_VT);
        add_text("%PDF-9.0");
        add_flush();
        add_flush();
        add_byte(8'h00);
        add_byte(CH_FF);
        add_byte(CH_SPACE);
        n_direct = req_q.size();

        long_done = 1'b0;
        while (req_q.size() < n_direct + RAND_REQS)
        begin
            if (!long_done && req_q.size() > 900)
            begin
                // long token
                add_byte(8'h61);
                add_rand_bytes(LONG_LEN - 1);
                long_done = 1'b1;
            end
            else
                add_token();
            for (int i = $urandom_range(3) == 0 ? 2 : 1; i > 0; i--)
                add_separator();
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (req_q.size() != 0 || in_valid)
            @(posedge clk);
        while (token_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
